[sv/cla_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the command line argument splitter.
// Has no dependencies; cla_parse and the top level refer to it by scoped names.
package cla_pkg;

	localparam int COUNT_BITS = 16;
	localparam int WIDE_BITS  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam int CH_BITS    = 16;

	localparam logic [CH_BITS-1:0] BACKSLASH_CODE = 16'h005C;
	localparam logic [CH_BITS-1:0] QUOTE_CODE     = 16'h0022;
	localparam logic [CH_BITS-1:0] SPACE_CODE     = 16'h0020;
	localparam logic [CH_BITS-1:0] EOL_CODE       = 16'h0000;

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef struct packed {
		logic [15:0] args_done;
		logic        line_end;
		logic        arg_end;
		logic [15:0] out_char;
		logic        emit_char;
		logic [15:0] backslash_run;
	} result_t;

	function automatic count_t sat_inc(input count_t v);
		return (v == {COUNT_BITS{1'b1}}) ? v : count_t'(v + 1'b1);
	endfunction

	function automatic logic [15:0] clamp16(input count_t v);
		logic [WIDE_BITS-1:0] wide;
		wide = WIDE_BITS'(v);
		return (wide > WIDE_BITS'(16'hFFFF)) ? 16'hFFFF : wide[15:0];
	endfunction

endpackage

[sv/cla_parse.sv]
`timescale 1ns / 1ps
// Parsing state and per-character update of the argument splitter.
// Depends on cla_pkg for the character codes, counter helpers and result type.
module cla_parse (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic                        cfg_wdata,
	input  logic                        fire,
	input  logic [cla_pkg::CH_BITS-1:0] ch,
	output logic                        has_result,
	output cla_pkg::result_t            result
);

	logic            keep_quotes_q;
	logic            in_arg_q;
	logic            in_quotes_q;
	cla_pkg::count_t pend_q;
	cla_pkg::count_t arg_cnt_q;

	logic            in_arg_n;
	logic            in_quotes_n;
	cla_pkg::count_t pend_n;
	cla_pkg::count_t arg_cnt_n;

	cla_pkg::count_t cnt_inc;
	cla_pkg::count_t eff_pend;
	logic            eff_quotes;
	logic            is_sep;
	logic            odd;

	always_comb begin
		cnt_inc     = cla_pkg::sat_inc(arg_cnt_q);
		is_sep      = (ch <= cla_pkg::SPACE_CODE);
		eff_pend    = in_arg_q ? pend_q : '0;
		eff_quotes  = in_arg_q ? in_quotes_q : 1'b0;
		odd         = eff_pend[0];
		in_arg_n    = in_arg_q;
		in_quotes_n = in_quotes_q;
		pend_n      = pend_q;
		arg_cnt_n   = arg_cnt_q;
		has_result  = 1'b0;
		result      = '0;
		result.args_done = cla_pkg::clamp16(arg_cnt_q);
		if (ch == cla_pkg::EOL_CODE) begin
			has_result      = 1'b1;
			result.line_end = 1'b1;
			if (in_arg_q) begin
				result.arg_end       = 1'b1;
				result.backslash_run = cla_pkg::clamp16(pend_q);
				result.args_done     = cla_pkg::clamp16(cnt_inc);
			end
			in_arg_n    = 1'b0;
			in_quotes_n = 1'b0;
			pend_n      = '0;
			arg_cnt_n   = '0;
		end else if (!in_arg_q && is_sep) begin
			has_result = 1'b0;
		end else if (in_arg_q && !in_quotes_q && is_sep) begin
			has_result           = 1'b1;
			result.arg_end       = 1'b1;
			result.backslash_run = cla_pkg::clamp16(pend_q);
			result.args_done     = cla_pkg::clamp16(cnt_inc);
			arg_cnt_n            = cnt_inc;
			in_arg_n             = 1'b0;
			pend_n               = '0;
		end else begin
			in_arg_n    = 1'b1;
			in_quotes_n = eff_quotes;
			if (ch == cla_pkg::BACKSLASH_CODE) begin
				pend_n = cla_pkg::sat_inc(eff_pend);
			end else begin
				pend_n     = '0;
				has_result = 1'b1;
				if (ch == cla_pkg::QUOTE_CODE) begin
					if (!odd) begin
						in_quotes_n = !eff_quotes;
					end
					if (keep_quotes_q && (arg_cnt_q == '0)) begin
						result.backslash_run = cla_pkg::clamp16(eff_pend);
						result.emit_char     = 1'b1;
						result.out_char      = ch;
					end else begin
						result.backslash_run = cla_pkg::clamp16(eff_pend >> 1);
						result.emit_char     = odd;
						result.out_char      = odd ? ch : '0;
					end
				end else begin
					result.backslash_run = cla_pkg::clamp16(eff_pend);
					result.emit_char     = 1'b1;
					result.out_char      = ch;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_quotes_q <= 1'b1;
			in_arg_q      <= 1'b0;
			in_quotes_q   <= 1'b0;
			pend_q        <= '0;
			arg_cnt_q     <= '0;
		end else begin
			if (cfg_wen) begin
				keep_quotes_q <= cfg_wdata;
			end
			if (fire) begin
				in_arg_q    <= in_arg_n;
				in_quotes_q <= in_quotes_n;
				pend_q      <= pend_n;
				arg_cnt_q   <= arg_cnt_n;
			end
		end
	end

endmodule

[sv/command_line_arg_splitter.sv]
`timescale 1ns / 1ps
// A character accepted on the slave side passes through the input register, then the result
// register, and reaches the master side as a result beat once the sink is ready.
// One character per cycle unless stalled; backslashes and extra blanks give no beat.
// Reset: arst_n clears the parsing state and both pipeline stages; the quote mode
// register returns to 1. Depends on cla_pkg and cla_parse.
module command_line_arg_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // ch [15:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // backslash_run [15:0], out_char [31:16], args_done [47:32]
	output logic [1:0]  m_tuser,   // emit_char [0], arg_end [1]
	output logic        m_tlast    // line_end
);

	logic                        valid_s1;
	logic [cla_pkg::CH_BITS-1:0] ch_s1;
	logic                        valid_s2;
	cla_pkg::result_t            res_s2;

	logic             stall;
	logic             fire;
	logic             has_result;
	cla_pkg::result_t result;

	assign stall    = valid_s2 && !m_tready;
	assign fire     = valid_s1 && !stall;
	assign s_tready = !valid_s1 || !stall;

	cla_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.fire       (fire),
		.ch         (ch_s1),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (!stall) begin
				valid_s2 <= fire && has_result;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1 <= s_tdata;
		end
		if (fire && has_result) begin
			res_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.args_done, res_s2.out_char, res_s2.backslash_run};
	assign m_tuser  = {res_s2.arg_end, res_s2.emit_char};
	assign m_tlast  = res_s2.line_end;

endmodule

[sv/cla_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the argument splitter, attached by the bind at the end.
// Depends only on the top level's ports.
module cla_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// A beat that carries no character must show a zero character.
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[31:16] == 16'h0000)
		else $error("out_char not zero on a beat without a character");

	// A closed argument is always counted.
	a_arg_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[47:32] != 16'h0000)
		else $error("argument end with a zero argument count");

	// A ready sink never holds back the slave side.
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("slave side stalled although the master side is ready");

	// A stalled result beat keeps its content.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result beat changed while stalled");

endmodule

bind command_line_arg_splitter cla_checker u_cla_checker (.*);
